// File: sv/cfpp_pkg.sv
`timescale 1ns / 1ps

package cfpp_pkg;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MOVE,
        OP_LINE,
        OP_ARC,
        OP_CURVE,
        OP_END
    } op_code_t;

    typedef enum logic [2:0] {
        FACE_EAST,
        FACE_WEST,
        FACE_SOUTH,
        FACE_NORTH,
        FACE_FRONT,
        FACE_BACK
    } face_t;

    typedef enum logic [1:0] {
        ST_USED,
        ST_RANGE,
        ST_INVALID
    } status_t;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 1'b1;

    localparam logic [14:0] NEAR_LIMIT_RST  = 15'd983;
    localparam logic [15:0] RANGE_LIMIT_RST = 16'd17039;

    // divider geometry: dividend is |num| << 14, at most 30 bits, padded to 32
    localparam int DIV_W        = 32;
    localparam int DEN_W        = 16;
    localparam int REM_W        = DEN_W + 1;
    localparam int DIV_STEP     = 4;
    localparam int DIV_STAGES   = DIV_W / DIV_STEP;
    localparam int PIPE_LATENCY = DIV_STAGES + 2;
    localparam int LIM_W        = 17;

    typedef struct packed {
        logic [2:0]         op_code;
        logic [2:0]         face;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [15:0]        arc_radius;
    } cfpp_in_t;

    typedef struct packed {
        logic [2:0]         out_op;
        logic [1:0]         status;
        logic signed [23:0] face_x;
        logic signed [23:0] face_y;
        logic signed [15:0] depth;
    } cfpp_out_t;

    // side information that travels alongside the divider lanes
    typedef struct packed {
        logic [2:0]         op;
        logic               fixed;
        logic [1:0]         status;
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic signed [15:0] depth;
        logic [LIM_W-1:0]   lim;
        logic               neg_x;
        logic               neg_y;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] dvd;
        logic [DIV_W-1:0] quo;
        logic [DEN_W-1:0] den;
    } div_state_t;

    // restoring division, DIV_STEP quotient bits
    function automatic div_state_t div_step(input div_state_t s);
        div_state_t       r;
        logic [REM_W-1:0] trial;
        r = s;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {r.rem[REM_W-2:0], r.dvd[DIV_W-1]};
            r.dvd = {r.dvd[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r.den})
            begin
                r.rem = trial - {1'b0, r.den};
                r.quo = {r.quo[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = trial;
                r.quo = {r.quo[DIV_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// File: sv/cfpp_decode.sv
`timescale 1ns / 1ps

module cfpp_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  cfpp_pkg::cfpp_in_t    cmd,
    input  logic [14:0]           near_limit,
    input  logic [15:0]           range_limit,
    output logic                  out_valid,
    output cfpp_pkg::side_t       side,
    output logic [31:0]           dvd_x,
    output logic [15:0]           den_x,
    output logic [31:0]           dvd_y,
    output logic [15:0]           den_y
);
    import cfpp_pkg::*;

    logic               valid_reg;
    side_t              side_reg;
    side_t              side_next;
    logic [DIV_W-1:0]   dvd_x_reg, dvd_x_next;
    logic [DIV_W-1:0]   dvd_y_reg, dvd_y_next;
    logic [DEN_W-1:0]   den_x_reg, den_x_next;
    logic [DEN_W-1:0]   den_y_reg, den_y_next;

    logic signed [16:0] px, py, pz;
    logic signed [16:0] dep, nx, ny;
    logic signed [16:0] nx_neg, ny_neg;
    logic [15:0]        mag_x, mag_y;
    logic               bad_face;
    logic               behind;
    logic signed [15:0] dep_sat;

    always_comb
    begin
        px = 17'(cmd.point_x);
        py = 17'(cmd.point_y);
        pz = 17'(cmd.point_z);
        bad_face = 1'b0;
        case (cmd.face)
            FACE_EAST:
            begin
                dep = px;  nx = -pz; ny = -py;
            end
            FACE_WEST:
            begin
                dep = -px; nx = pz;  ny = -py;
            end
            FACE_SOUTH:
            begin
                dep = -py; nx = px;  ny = -pz;
            end
            FACE_NORTH:
            begin
                dep = py;  nx = px;  ny = pz;
            end
            FACE_FRONT:
            begin
                dep = pz;  nx = px;  ny = -py;
            end
            FACE_BACK:
            begin
                dep = -pz; nx = -px; ny = -py;
            end
            default:
            begin
                dep = '0;  nx = '0;  ny = '0;
                bad_face = 1'b1;
            end
        endcase

        nx_neg = -nx;
        ny_neg = -ny;
        mag_x  = nx[16] ? nx_neg[15:0] : nx[15:0];
        mag_y  = ny[16] ? ny_neg[15:0] : ny[15:0];

        behind  = dep < $signed({2'b00, near_limit});
        dep_sat = (dep > 17'sd32767) ? 16'sh7fff : dep[15:0];

        dvd_x_next = {2'b00, mag_x, 14'd0};
        dvd_y_next = {2'b00, mag_y, 14'd0};
        // a zero numerator must give zero even at zero depth
        den_x_next = (mag_x == 16'd0) ? 16'd1 : dep[15:0];
        den_y_next = (mag_y == 16'd0) ? 16'd1 : dep[15:0];

        side_next.op    = cmd.op_code;
        side_next.neg_x = nx[16];
        side_next.neg_y = ny[16];
        side_next.lim   = {1'b0, range_limit}
                        + ((cmd.op_code == OP_ARC) ? {1'b0, cmd.arc_radius} : 17'd0);
        if (bad_face)
        begin
            side_next.fixed  = 1'b1;
            side_next.status = ST_INVALID;
            side_next.fx     = '0;
            side_next.fy     = '0;
            side_next.depth  = '0;
        end
        else if (cmd.op_code == OP_END)
        begin
            side_next.fixed  = 1'b1;
            side_next.status = ST_USED;
            side_next.fx     = 24'(cmd.point_x);
            side_next.fy     = 24'(cmd.point_y);
            side_next.depth  = cmd.point_z;
        end
        else if (behind)
        begin
            side_next.fixed  = 1'b1;
            side_next.status = ST_INVALID;
            side_next.fx     = '0;
            side_next.fy     = '0;
            side_next.depth  = dep_sat;
        end
        else
        begin
            side_next.fixed  = 1'b0;
            side_next.status = ST_USED;
            side_next.fx     = '0;
            side_next.fy     = '0;
            side_next.depth  = dep_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg  <= side_next;
        dvd_x_reg <= dvd_x_next;
        dvd_y_reg <= dvd_y_next;
        den_x_reg <= den_x_next;
        den_y_reg <= den_y_next;
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign dvd_x     = dvd_x_reg;
    assign dvd_y     = dvd_y_reg;
    assign den_x     = den_x_reg;
    assign den_y     = den_y_reg;

endmodule

// File: sv/cfpp_divider.sv
`timescale 1ns / 1ps

module cfpp_divider (
    input  logic        clk,
    input  logic [31:0] dvd,
    input  logic [15:0] den,
    output logic [31:0] quo
);
    import cfpp_pkg::*;

    div_state_t stage_in;
    div_state_t stage_next [DIV_STAGES];
    div_state_t stage_reg  [DIV_STAGES];

    assign stage_in = '{rem: '0, dvd: dvd, quo: '0, den: den};

    always_comb
    begin
        stage_next[0] = div_step(stage_in);
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            stage_next[s] = div_step(stage_reg[s-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    assign quo = stage_reg[DIV_STAGES-1].quo;

endmodule

// File: sv/cfpp_finish.sv
`timescale 1ns / 1ps

module cfpp_finish (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  cfpp_pkg::side_t       side,
    input  logic [31:0]           quo_x,
    input  logic [31:0]           quo_y,
    output logic                  result_valid,
    output cfpp_pkg::cfpp_out_t   result
);
    import cfpp_pkg::*;

    logic               result_valid_reg;
    cfpp_out_t          result_reg;
    cfpp_out_t          result_next;
    logic [DIV_W-1:0]   lim_w;
    logic               out_of_range;
    logic signed [23:0] sat_x, sat_y;

    function automatic logic signed [23:0] sat_quo(input logic [DIV_W-1:0] mag,
                                                   input logic neg);
        logic [23:0] low;
        low = mag[23:0];
        if (neg)
        begin
            return (mag > 32'h0080_0000) ? 24'sh800000 : $signed(-low);
        end
        else
        begin
            return (mag > 32'h007f_ffff) ? 24'sh7fffff : $signed(low);
        end
    endfunction

    always_comb
    begin
        lim_w        = DIV_W'(side.lim);
        out_of_range = (quo_x > lim_w) || (quo_y > lim_w);
        sat_x        = sat_quo(quo_x, side.neg_x);
        sat_y        = sat_quo(quo_y, side.neg_y);

        result_next.out_op = side.op;
        result_next.depth  = side.depth;
        if (side.fixed)
        begin
            result_next.status = side.status;
            result_next.face_x = side.fx;
            result_next.face_y = side.fy;
        end
        else
        begin
            result_next.status = out_of_range ? ST_RANGE : ST_USED;
            result_next.face_x = sat_x;
            result_next.face_y = sat_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: sv/cube_face_point_projection.sv
// channel   direction  handshake               word
// command   in         start, busy             cmd
// config    in         cfg_valid, cfg_ready    cfg_index, cfg_data
// result    out        result_valid strobe     result
//
// a point is taken every cycle; busy stays low, cfg_ready stays high
// the pipeline runs decode, eight 4-bit stages of the two divider lanes, finish
// the divider pipeline sets the depth; both lanes run in lockstep
// reset clears the valid bits and loads the limit registers with their defaults
// the receiver cannot stall, so nothing in the pipeline ever holds
`timescale 1ns / 1ps

module cube_face_point_projection (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  cfpp_pkg::cfpp_in_t                     cmd,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cfpp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [15:0]                            cfg_data,
    output logic                                   result_valid,
    output cfpp_pkg::cfpp_out_t                    result
);
    import cfpp_pkg::*;

    logic [14:0] near_limit_reg;
    logic [15:0] range_limit_reg;

    logic              dec_valid;
    side_t             dec_side;
    logic [DIV_W-1:0]  dvd_x, dvd_y;
    logic [DEN_W-1:0]  den_x, den_y;
    logic [DIV_W-1:0]  quo_x, quo_y;

    logic  vld_pipe_reg  [DIV_STAGES];
    side_t side_pipe_reg [DIV_STAGES];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_limit_reg  <= NEAR_LIMIT_RST;
            range_limit_reg <= RANGE_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NEAR_LIMIT:  near_limit_reg  <= cfg_data[14:0];
                CFG_RANGE_LIMIT: range_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    cfpp_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start & ~busy),
        .cmd         (cmd),
        .near_limit  (near_limit_reg),
        .range_limit (range_limit_reg),
        .out_valid   (dec_valid),
        .side        (dec_side),
        .dvd_x       (dvd_x),
        .den_x       (den_x),
        .dvd_y       (dvd_y),
        .den_y       (den_y)
    );

    cfpp_divider u_div_x (
        .clk (clk),
        .dvd (dvd_x),
        .den (den_x),
        .quo (quo_x)
    );

    cfpp_divider u_div_y (
        .clk (clk),
        .dvd (dvd_y),
        .den (den_y),
        .quo (quo_y)
    );

    // side words follow the divider lanes stage for stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                vld_pipe_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_pipe_reg[0] <= dec_valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                vld_pipe_reg[s] <= vld_pipe_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= dec_side;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            side_pipe_reg[s] <= side_pipe_reg[s-1];
        end
    end

    cfpp_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (vld_pipe_reg[DIV_STAGES-1]),
        .side         (side_pipe_reg[DIV_STAGES-1]),
        .quo_x        (quo_x),
        .quo_y        (quo_y),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LATENCY result_valid)
        else $error("accepted word did not come out after the pipeline latency");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_INVALID) |->
            (result.face_x == 24'sd0 && result.face_y == 24'sd0))
        else $error("invalid result carries a nonzero projected point");

    a_bad_face: assert property (@(posedge clk) disable iff (!rst_n)
        (start && cmd.face > FACE_BACK) |->
            ##PIPE_LATENCY (result.status == ST_INVALID && result.depth == 16'sd0))
        else $error("unknown face did not give an invalid result");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

class projection_scoreboard;
    logic [14:0]         near_lim;
    logic [15:0]         range_lim;
    cfpp_pkg::cfpp_out_t expected_q[$];
    int                  errors;

    function new();
        near_lim  = cfpp_pkg::NEAR_LIMIT_RST;
        range_lim = cfpp_pkg::RANGE_LIMIT_RST;
        errors    = 0;
    endfunction

    function void set_limit(logic [cfpp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        if (idx == cfpp_pkg::CFG_NEAR_LIMIT)
        begin
            near_lim = val[14:0];
        end
        else
        begin
            range_lim = val;
        end
    endfunction

    function logic [23:0] sat24(longint v);
        if (v > 64'sd8388607)
        begin
            return 24'h7FFFFF;
        end
        if (v < -64'sd8388608)
        begin
            return 24'h800000;
        end
        return v[23:0];
    endfunction

    // numerator scaled by 2^14 over depth; zero depth goes to the extreme of its sign
    function longint face_quotient(int num, int den);
        if (den == 0)
        begin
            if (num > 0)
            begin
                return 64'sd8388608;
            end
            if (num < 0)
            begin
                return -64'sd8388609;
            end
            return 0;
        end
        return (longint'(num) * 16384) / longint'(den);
    endfunction

    function cfpp_pkg::cfpp_out_t project(cfpp_pkg::cfpp_in_t p);
        cfpp_pkg::cfpp_out_t r;
        int                  px, py, pz, d, nx, ny;
        longint              qx, qy, lim;
        px = $signed(p.point_x);
        py = $signed(p.point_y);
        pz = $signed(p.point_z);
        r = '0;
        r.out_op = p.op_code;
        case (p.face)
            cfpp_pkg::FACE_EAST:  begin d = px;  nx = -pz; ny = -py; end
            cfpp_pkg::FACE_WEST:  begin d = -px; nx = pz;  ny = -py; end
            cfpp_pkg::FACE_SOUTH: begin d = -py; nx = px;  ny = -pz; end
            cfpp_pkg::FACE_NORTH: begin d = py;  nx = px;  ny = pz;  end
            cfpp_pkg::FACE_FRONT: begin d = pz;  nx = px;  ny = -py; end
            cfpp_pkg::FACE_BACK:  begin d = -pz; nx = -px; ny = -py; end
            default:
            begin
                r.status = cfpp_pkg::ST_INVALID;
                return r;
            end
        endcase
        if (p.op_code == cfpp_pkg::OP_END)
        begin
            r.status = cfpp_pkg::ST_USED;
            r.face_x = 24'(px);
            r.face_y = 24'(py);
            r.depth  = 16'(pz);
            return r;
        end
        r.depth = (d > 32767) ? 16'sh7FFF : 16'(d);
        if (d < int'(near_lim))
        begin
            r.status = cfpp_pkg::ST_INVALID;
            return r;
        end
        qx = face_quotient(nx, d);
        qy = face_quotient(ny, d);
        r.face_x = sat24(qx);
        r.face_y = sat24(qy);
        lim = longint'(range_lim);
        if (p.op_code == cfpp_pkg::OP_ARC)
        begin
            lim = lim + longint'(p.arc_radius);
        end
        if (qx < -lim || qx > lim || qy < -lim || qy > lim)
        begin
            r.status = cfpp_pkg::ST_RANGE;
        end
        else
        begin
            r.status = cfpp_pkg::ST_USED;
        end
        return r;
    endfunction

    function void note_point(cfpp_pkg::cfpp_in_t p);
        expected_q.push_back(project(p));
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void report(string name, longint want, longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
    endfunction

    function void check_result(cfpp_pkg::cfpp_out_t got);
        cfpp_pkg::cfpp_out_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, actual %p", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got.out_op !== want.out_op)
        begin
            report("out_op", want.out_op, got.out_op);
        end
        if (got.status !== want.status)
        begin
            report("status", want.status, got.status);
        end
        if (got.face_x !== want.face_x)
        begin
            report("face_x", want.face_x, got.face_x);
        end
        if (got.face_y !== want.face_y)
        begin
            report("face_y", want.face_y, got.face_y);
        end
        if (got.depth !== want.depth)
        begin
            report("depth", want.depth, got.depth);
        end
    endfunction
endclass

module testbench;
    import cfpp_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [2:0]  OP_SPARE_LO   = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI   = 3'd7;
    localparam logic [2:0]  FACE_SPARE_LO = 3'd6;
    localparam logic [2:0]  FACE_SPARE_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cfpp_in_t             cmd;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;
    logic                 result_valid;
    cfpp_out_t            result;

    projection_scoreboard sb;
    int                   cycles;

    cube_face_point_projection u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            sb.check_result(result);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL cube_face_point_projection");
        $finish;
    end

    function automatic cfpp_in_t make_point(logic [2:0] op, logic [2:0] face,
                                            int x, int y, int z, int rad);
        cfpp_in_t p;
        p.op_code    = op;
        p.face       = face;
        p.point_x    = 16'(x);
        p.point_y    = 16'(y);
        p.point_z    = 16'(z);
        p.arc_radius = 16'(rad);
        return p;
    endfunction

    // mostly points that face the chosen face, so the divide and range check get exercised
    function automatic cfpp_in_t random_point();
        cfpp_in_t p;
        int       c[3];
        int       axis, m, a, b, mag;
        bit       neg;
        p.op_code = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                                : 3'($urandom_range(OP_NONE, OP_END));
        p.face = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(FACE_SPARE_LO, FACE_SPARE_HI))
                                             : 3'($urandom_range(FACE_EAST, FACE_BACK));
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                c[i] = $signed(16'($urandom));
            end
            else
            begin
                c[i] = int'($urandom_range(0, 32768)) - 16384;
            end
        end
        if (p.face <= FACE_BACK && $urandom_range(0, 9) < 7)
        begin
            axis = p.face / 2;
            neg  = (p.face == FACE_WEST || p.face == FACE_SOUTH || p.face == FACE_BACK);
            a    = c[(axis + 1) % 3];
            b    = c[(axis + 2) % 3];
            a    = (a < 0) ? -a : a;
            b    = (b < 0) ? -b : b;
            m    = (a > b) ? a : b;
            mag  = $urandom_range(m, 16384);
            if (mag > 32767)
            begin
                mag = 32767;
            end
            c[axis] = neg ? -mag : mag;
        end
        p.point_x    = 16'(c[0]);
        p.point_y    = 16'(c[1]);
        p.point_z    = 16'(c[2]);
        p.arc_radius = 16'($urandom);
        return p;
    endfunction

    task automatic send_point(cfpp_in_t p, int gap);
        @(negedge clk);
        start <= 1'b1;
        cmd   <= p;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note_point(p);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic go_idle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.set_limit(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, bit with_gaps);
        int gap;
        for (int i = 0; i < count; i++)
        begin
            gap = (with_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
            send_point(random_point(), gap);
        end
        go_idle();
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NEAR_LIMIT;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset limits: every face, close, spare codes, near-plane edge, range edge
        send_point(make_point(OP_MOVE, FACE_EAST, 16384, 0, 0, 0), 0);
        send_point(make_point(OP_LINE, FACE_WEST, -16384, 5000, -7000, 0), 0);
        send_point(make_point(OP_NONE, FACE_SOUTH, 3000, -16384, 9000, 0), 0);
        send_point(make_point(OP_CURVE, FACE_NORTH, -9000, 16384, 4000, 0), 0);
        send_point(make_point(OP_MOVE, FACE_FRONT, 8000, -8000, 16384, 0), 0);
        send_point(make_point(OP_LINE, FACE_BACK, -12000, 11000, -16384, 0), 0);
        send_point(make_point(OP_END, FACE_NORTH, -32768, 32767, -32768, 65535), 0);
        send_point(make_point(OP_END, FACE_SPARE_HI, 1234, -1234, 777, 0), 0);
        send_point(make_point(OP_LINE, FACE_SPARE_LO, 16384, 16384, 16384, 0), 0);
        send_point(make_point(OP_SPARE_LO, FACE_EAST, 16384, -300, 200, 0), 0);
        send_point(make_point(OP_SPARE_HI, FACE_FRONT, 100, 200, 16384, 0), 0);
        send_point(make_point(OP_LINE, FACE_EAST, 982, 100, 100, 0), 0);
        send_point(make_point(OP_LINE, FACE_EAST, 983, 0, 16384, 0), 0);
        send_point(make_point(OP_LINE, FACE_EAST, 0, 0, 0, 0), 0);
        send_point(make_point(OP_MOVE, FACE_EAST, -16384, 0, 0, 0), 0);
        send_point(make_point(OP_ARC, FACE_FRONT, 17139, 0, 16384, 100), 0);
        send_point(make_point(OP_ARC, FACE_FRONT, 17139, 0, 16384, 99), 0);
        send_point(make_point(OP_LINE, FACE_FRONT, 17039, -17039, 16384, 0), 0);
        send_point(make_point(OP_LINE, FACE_FRONT, 17040, 0, 16384, 0), 0);
        send_point(make_point(OP_ARC, FACE_NORTH, 32767, 32767, 983, 65535), 0);
        send_point(make_point(OP_MOVE, FACE_WEST, -32768, -32768, 32767, 0), 0);
        go_idle();
        wait_drain();

        // lowest limits: zero depth can pass the near plane
        write_limit(CFG_NEAR_LIMIT, 16'd0);
        write_limit(CFG_RANGE_LIMIT, 16'd0);
        send_point(make_point(OP_LINE, FACE_EAST, 0, 0, 0, 0), 0);
        send_point(make_point(OP_LINE, FACE_EAST, 0, 7, 5, 0), 0);
        send_point(make_point(OP_LINE, FACE_EAST, 0, -7, -5, 0), 0);
        send_point(make_point(OP_MOVE, FACE_EAST, 1, 32767, -32768, 0), 0);
        send_point(make_point(OP_ARC, FACE_NORTH, 1, 1, 0, 0), 0);
        run_random(60, 1'b1);
        wait_drain();

        // highest limits; data bit 15 is dropped for the near limit
        write_limit(CFG_NEAR_LIMIT, 16'hFFFF);
        write_limit(CFG_RANGE_LIMIT, 16'hFFFF);
        send_point(make_point(OP_LINE, FACE_WEST, -32768, 32767, -32768, 0), 0);
        send_point(make_point(OP_LINE, FACE_NORTH, 0, 32767, 0, 0), 0);
        send_point(make_point(OP_LINE, FACE_NORTH, 0, 32766, 0, 0), 0);
        run_random(40, 1'b1);
        wait_drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            write_limit(CFG_NEAR_LIMIT, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                    : 16'($urandom_range(0, 16384)));
            write_limit(CFG_RANGE_LIMIT, 16'($urandom));
            run_random(100, 1'b1);
            wait_drain();
        end

        // closing stretch back to back
        write_limit(CFG_NEAR_LIMIT, 16'(NEAR_LIMIT_RST));
        write_limit(CFG_RANGE_LIMIT, 16'($urandom_range(8192, 32768)));
        run_random(150, 1'b0);
        wait_drain();

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("PASS cube_face_point_projection");
        end
        else
        begin
            $display("FAIL cube_face_point_projection");
        end
        $finish;
    end
endmodule

// File: filelist.f
sv/cfpp_pkg.sv
sv/cfpp_decode.sv
sv/cfpp_divider.sv
sv/cfpp_finish.sv
sv/cube_face_point_projection.sv
dv/testbench.sv
